>>> design/gbrs_pkg.sv
package gbrs_pkg;

  // Defaults for the size parameters of the top level.
  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT0 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT1 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT2 = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT3 = 3'd6;

  // Register values after reset.
  localparam logic [1:0]  RADIUS_RST  = 2'd1;
  localparam logic [10:0] WIDTH_RST   = 11'd640;
  localparam logic [12:0] HEIGHT_RST  = 13'd480;
  localparam logic [15:0] WEIGHT0_RST = 16'd29614;
  localparam logic [15:0] WEIGHT1_RST = 16'd17961;
  localparam logic [15:0] WEIGHT2_RST = 16'd0;
  localparam logic [15:0] WEIGHT3_RST = 16'd0;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Q0.16 times Q0.16 gives Q0.32; the integer part starts here.
  localparam int FRAC_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int PIX_W = 24;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef logic [3:0][WEIGHT_W-1:0] weight_set_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_READ,
    S_WAIT,
    S_OUT
  } state_t;

  // One-dimensional weight for an absolute offset; offsets past three weigh nothing.
  function automatic logic [WEIGHT_W-1:0] weight_pick(input weight_set_t w,
                                                      input logic [2:0] d);
    logic [WEIGHT_W-1:0] res;
    case (d)
      3'd0: res = w[0];
      3'd1: res = w[1];
      3'd2: res = w[2];
      3'd3: res = w[3];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> design/gbrs_ram.sv
module gbrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/gbrs_cell.sv
module gbrs_cell #(
  parameter int ACC_W = 27
) (
  input  logic                  clk,
  input  logic                  en,
  input  gbrs_pkg::rgb_t        pix,
  input  logic [15:0]           wt,
  input  logic [2:0][ACC_W-1:0] acc_in,
  output logic [2:0][ACC_W-1:0] acc_out
);

  import gbrs_pkg::*;

  logic [23:0] prod_r, prod_g, prod_b;

  always_comb begin
    prod_r = pix.red * wt;
    prod_g = pix.green * wt;
    prod_b = pix.blue * wt;
  end

  // Transposed tap: the partial sum moves one cell down the row per fed pixel.
  always_ff @(posedge clk) begin
    if (en) begin
      acc_out[2] <= acc_in[2] + ACC_W'(prod_r);
      acc_out[1] <= acc_in[1] + ACC_W'(prod_g);
      acc_out[0] <= acc_in[0] + ACC_W'(prod_b);
    end
  end

endmodule

>>> design/gaussian_blur_rgb_stream.sv
// Gaussian blur of an RGB frame streamed in raster order, border pixels
// replicated. Each transfer on the input carries either a pixel or a flush
// tick; once the frame is complete, flush ticks push the remaining results
// out. Result n leaves after input step n + R*W + R, and frame_end marks the
// last pixel of the frame, after which both counters start over. Every input
// transfer is accepted, then passes the step and check states before the
// next is taken. When it releases a result, the window is read from the
// row memory one pixel per cycle through its single read port, and the
// result is then loaded into the output register. The row memory keeps
// 3*MAX_RADIUS+1 rows and needs no clearing after reset.
module gaussian_blur_rgb_stream #(
  parameter int MAX_RADIUS = gbrs_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH  = gbrs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gbrs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gbrs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             frame_end
);

  import gbrs_pkg::*;

  // Sizes that follow from the parameters.
  localparam int K      = 2 * MAX_RADIUS + 1;          // cells in the row
  localparam int RING   = 3 * MAX_RADIUS + 1;          // rows kept in memory
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int SLOT_W = $clog2(RING);
  localparam int R_W    = $clog2(MAX_RADIUS + 1);
  localparam int KI_W   = $clog2(K);
  localparam int OFF_W  = KI_W + 1;
  localparam int SS_W   = SLOT_W + OFF_W;
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                 + MAX_RADIUS + 2);
  localparam int HSUM_W = PIX_W + $clog2(K);
  localparam int VPRD_W = HSUM_W + WEIGHT_W;
  localparam int VACC_W = VPRD_W + $clog2(K);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = RING * (2 ** COL_W);

  // Configuration registers.
  logic [1:0]  radius;
  logic [10:0] image_width;
  logic [12:0] image_height;
  weight_set_t weights;

  logic [W_W-1:0]   eff_w;
  logic [H_W-1:0]   eff_h;
  logic [R_W-1:0]   eff_r;
  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] lag_reg;

  state_t state, state_next;

  // Item held while it is processed.
  logic item_cmd;
  rgb_t item_px;

  // Frame counters and raster positions.
  logic [CNT_W-1:0]  ic, oc;
  logic [COL_W-1:0]  in_col, out_col;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [ROW_W-1:0]  out_row;

  // Bookkeeping of one step.
  logic              restart, in_room, store, in_wrap, emit;
  logic [CNT_W-1:0]  ic0;
  logic [COL_W-1:0]  in_col0;
  logic [SLOT_W-1:0] in_slot0;

  // Window sweep.
  logic [KI_W-1:0]         dr_idx, dc_idx;
  logic                    last_col, last_row, last_issue;
  logic signed [OFF_W-1:0] r_s, dr_off, dc_off, dc_clip, dr_eff;
  logic signed [ROW_W+1:0] row_s, out_row_s, hmax;
  logic signed [SS_W-1:0]  slot_s;
  logic signed [COL_W+1:0] col_s, wmax;
  logic [SLOT_W-1:0]       rd_slot;
  logic [COL_W-1:0]        rd_col;
  logic [R_W-1:0]          abs_dr;

  // Control decoded from the state.
  logic ram_we, issue, out_free, out_load;

  // Pipeline behind the memory.
  logic [PIX_W-1:0] rd_data;
  logic              s1_v, s1_lastc, s1_lastr;
  logic [R_W-1:0]    s1_wsel;
  logic              s2_v, s2_lastr;
  logic [R_W-1:0]    s2_wsel;
  logic              s3_v, s3_lastr;
  logic              s4_done;
  logic [K-1:0][WEIGHT_W-1:0]     cell_wt;
  logic [K-1:0][2:0][HSUM_W-1:0]  acc;
  logic [WEIGHT_W-1:0]            wrow;
  logic [2:0][VPRD_W-1:0]         vprod;
  logic [2:0][VACC_W-1:0]         vacc;
  logic [2:0][VACC_W-1:0]         vshift;
  logic [2:0][7:0]                sat;
  logic                           last_out, out_wrap;

  // Register values as used: zero sizes count as one, oversize values clip.
  always_comb begin
    if (image_width == '0) begin
      eff_w = W_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(image_width);
    end
    if (image_height == '0) begin
      eff_h = H_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = H_W'(MAX_HEIGHT);
    end else begin
      eff_h = H_W'(image_height);
    end
    if (32'(radius) > 32'(MAX_RADIUS)) begin
      eff_r = R_W'(MAX_RADIUS);
    end else begin
      eff_r = R_W'(radius);
    end
  end

  // Configuration writes, plus frame size and lag registered from them. The
  // derived values settle in the cycle after a write, before any item they
  // govern reaches its bookkeeping step.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RADIUS_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      weights[0]   <= WEIGHT0_RST;
      weights[1]   <= WEIGHT1_RST;
      weights[2]   <= WEIGHT2_RST;
      weights[3]   <= WEIGHT3_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RADIUS:  radius       <= cfg_data[1:0];
        CFG_WIDTH:   image_width  <= cfg_data[10:0];
        CFG_HEIGHT:  image_height <= cfg_data[12:0];
        CFG_WEIGHT0: weights[0]   <= cfg_data;
        CFG_WEIGHT1: weights[1]   <= cfg_data;
        CFG_WEIGHT2: weights[2]   <= cfg_data;
        CFG_WEIGHT3: weights[3]   <= cfg_data;
        default: ;
      endcase
    end
    n_reg   <= CNT_W'(CNT_W'(eff_w) * CNT_W'(eff_h));
    lag_reg <= CNT_W'(CNT_W'(eff_r) * CNT_W'(eff_w) + CNT_W'(eff_r));
  end

  // Step bookkeeping: restart check, then store the pixel or, once the frame is complete, count the step.
  always_comb begin
    restart  = (oc >= n_reg) || (ic > n_reg + lag_reg);
    ic0      = restart ? '0 : ic;
    in_col0  = restart ? '0 : in_col;
    in_slot0 = restart ? '0 : in_slot;
    in_room  = ic0 < n_reg;
    store    = in_room && (item_cmd == CMD_PIXEL);
    in_wrap  = (W_W'(in_col0) + W_W'(1)) >= eff_w;
    emit     = ic > oc + lag_reg;
  end

  // Window address: row and column offsets clamped to the frame, the row
  // mapped onto its ring slot relative to the slot of the output row.
  always_comb begin
    r_s      = $signed(OFF_W'(eff_r));
    dr_off   = $signed(OFF_W'(dr_idx)) - r_s;
    dc_off   = $signed(OFF_W'(dc_idx)) - $signed(OFF_W'(MAX_RADIUS));
    if (dc_off < -r_s) begin
      dc_clip = -r_s;
    end else if (dc_off > r_s) begin
      dc_clip = r_s;
    end else begin
      dc_clip = dc_off;
    end

    out_row_s = $signed((ROW_W + 2)'(out_row));
    hmax      = $signed((ROW_W + 2)'(eff_h)) - $signed((ROW_W + 2)'(1));
    row_s     = out_row_s + (ROW_W + 2)'(dr_off);
    if (row_s < 0) begin
      dr_eff = OFF_W'(-out_row_s);
    end else if (row_s > hmax) begin
      dr_eff = OFF_W'(hmax - out_row_s);
    end else begin
      dr_eff = dr_off;
    end
    slot_s = $signed(SS_W'(out_slot)) + SS_W'(dr_eff);
    if (slot_s < 0) begin
      rd_slot = SLOT_W'(slot_s + $signed(SS_W'(RING)));
    end else if (slot_s >= $signed(SS_W'(RING))) begin
      rd_slot = SLOT_W'(slot_s - $signed(SS_W'(RING)));
    end else begin
      rd_slot = SLOT_W'(slot_s);
    end

    wmax  = $signed((COL_W + 2)'(eff_w)) - $signed((COL_W + 2)'(1));
    col_s = $signed((COL_W + 2)'(out_col)) + (COL_W + 2)'(dc_clip);
    if (col_s < 0) begin
      rd_col = '0;
    end else if (col_s > wmax) begin
      rd_col = COL_W'(wmax);
    end else begin
      rd_col = COL_W'(col_s);
    end

    abs_dr     = (dr_off < 0) ? R_W'(-dr_off) : R_W'(dr_off);
    last_col   = dc_idx == KI_W'(K - 1);
    last_row   = dr_idx == KI_W'(2 * eff_r);
    last_issue = last_col && last_row;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_STEP;
      S_STEP:  state_next = S_CHECK;
      S_CHECK: state_next = emit ? S_READ : S_IDLE;
      S_READ:  if (last_issue) state_next = S_WAIT;
      S_WAIT:  if (s4_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    out_free = !out_valid || !out_stall;
    in_stall = 1'b1;
    ram_we   = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: in_stall = 1'b0;
      S_STEP: ram_we   = store;
      S_READ: issue    = 1'b1;
      S_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item capture on an input transfer.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_cmd <= command;
      item_px  <= '{red: red, green: green, blue: blue};
    end
  end

  // Frame counters and raster positions.
  always_ff @(posedge clk) begin
    if (rst) begin
      ic       <= '0;
      oc       <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else if (state == S_STEP) begin
      if (restart) begin
        oc       <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
      end
      ic <= (store || !in_room) ? ic0 + CNT_W'(1) : ic0;
      if (store) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_slot <= (in_slot0 == SLOT_W'(RING - 1)) ? '0 : in_slot0 + SLOT_W'(1);
        end else begin
          in_col  <= in_col0 + COL_W'(1);
          in_slot <= in_slot0;
        end
      end else begin
        in_col  <= in_col0;
        in_slot <= in_slot0;
      end
    end else if (out_load) begin
      if (last_out) begin
        ic       <= '0;
        oc       <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_slot <= '0;
      end else begin
        oc <= oc + CNT_W'(1);
        if (out_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= (out_slot == SLOT_W'(RING - 1)) ? '0 : out_slot + SLOT_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // Window sweep counters: columns run fastest, one memory read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dr_idx <= '0;
      dc_idx <= '0;
    end else if (state == S_CHECK) begin
      dr_idx <= '0;
      dc_idx <= '0;
    end else if (issue) begin
      if (last_col) begin
        dc_idx <= '0;
        dr_idx <= dr_idx + KI_W'(1);
      end else begin
        dc_idx <= dc_idx + KI_W'(1);
      end
    end
  end

  gbrs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'({in_slot0, in_col0})),
    .wdata(item_px),
    .raddr(ADDR_W'({rd_slot, rd_col})),
    .rdata(rd_data)
  );

  // Tracking of the sweep through the read, cell and vertical stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_done <= 1'b0;
    end else begin
      s1_v    <= issue;
      s2_v    <= s1_v && s1_lastc;
      s3_v    <= s2_v;
      s4_done <= s3_v && s3_lastr;
    end
    s1_lastc <= last_col;
    s1_lastr <= last_row;
    s1_wsel  <= abs_dr;
    s2_lastr <= s1_lastr;
    s2_wsel  <= s1_wsel;
    s3_lastr <= s2_lastr;
  end

  // Row of cells: cell k weighs horizontal offset k - MAX_RADIUS, zero
  // outside the current radius. The last cell holds a full row sum in the
  // cycle after the last of the row's pixels went in.
  for (genvar k = 0; k < K; k++) begin : g_cell
    localparam int D = (k >= MAX_RADIUS) ? k - MAX_RADIUS : MAX_RADIUS - k;

    assign cell_wt[k] = (32'(D) <= 32'(eff_r)) ? weight_pick(weights, 3'(D)) : '0;

    if (k == 0) begin : g_first
      gbrs_cell #(
        .ACC_W(HSUM_W)
      ) u_cell (
        .clk    (clk),
        .en     (s1_v),
        .pix    (rgb_t'(rd_data)),
        .wt     (cell_wt[k]),
        .acc_in ('0),
        .acc_out(acc[k])
      );
    end else begin : g_next
      gbrs_cell #(
        .ACC_W(HSUM_W)
      ) u_cell (
        .clk    (clk),
        .en     (s1_v),
        .pix    (rgb_t'(rd_data)),
        .wt     (cell_wt[k]),
        .acc_in (acc[k-1]),
        .acc_out(acc[k])
      );
    end
  end

  // Vertical pass: row sum times the row weight, then accumulated exactly.
  assign wrow = weight_pick(weights, 3'(s2_wsel));

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (s2_v) begin
        vprod[c] <= VPRD_W'(VPRD_W'(acc[K-1][c]) * VPRD_W'(wrow));
      end
      if (state == S_CHECK) begin
        vacc[c] <= '0;
      end else if (s3_v) begin
        vacc[c] <= vacc[c] + VACC_W'(vprod[c]);
      end
    end
  end

  // Drop the fraction and clip to eight bits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vshift[c] = vacc[c] >> FRAC_W;
      sat[c]    = (vshift[c] > VACC_W'(255)) ? 8'hFF : vshift[c][7:0];
    end
    last_out = (oc + CNT_W'(1)) >= n_reg;
    out_wrap = (W_W'(out_col) + W_W'(1)) >= eff_w;
  end

  // Output register: a finished result waits here while the next item comes in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_red   <= sat[2];
      out_green <= sat[1];
      out_blue  <= sat[0];
      frame_end <= oc == (n_reg - CNT_W'(1));
    end
  end

`ifndef NO_ASSERTIONS
  // A result is never counted ahead of the input that releases it.
  a_count_order: assert property (@(posedge clk) disable iff (rst) oc <= ic)
    else $error("output count passed input count");

  // The last vertical accumulation only completes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    s4_done |-> state == S_WAIT)
    else $error("window sum finished outside the wait state");

  // Memory data only feeds the cells during or right after the sweep.
  a_feed_window: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> (state == S_READ || state == S_WAIT))
    else $error("cells fed outside a window sweep");
`endif

endmodule

>>> tb/sv/tb.sv
module tb;
  import gbrs_pkg::*;

  // One blurred pixel as the block hands it out.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_px_t;

  // One row of the directed stimulus table. Where typed is set, the expected
  // outcome is written into the row itself and has tells whether a transfer is
  // due; otherwise the blur predictor decides.
  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       typed;
    logic       has;
    blur_px_t   px;
  } dir_row_t;

  localparam int RING_ROWS   = 3 * MAX_RADIUS_DEF + 1;
  localparam int DRAIN_WAIT  = 80;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic frame_end;

  gaussian_blur_rgb_stream dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .frame_end(frame_end)
  );

  // Mirror of the block's registers, row ring and frame counters.
  logic [1:0]  blur_radius;
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [15:0] tap_weight [4];
  logic [23:0] row_ring [RING_ROWS][MAX_WIDTH_DEF];
  int unsigned pixels_in;
  int unsigned pixels_out;

  blur_px_t pending_px [$];
  dir_row_t dir_rows [$];

  int  failures;
  int  items_sent;
  int  results_seen;
  int  frames_done;
  int  cycles;
  bit  quiet;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off if the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_px.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls in random bursts, except in the quiet tail of the run.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned eff_width();
    if (frame_width == 0) return 1;
    return frame_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : frame_width;
  endfunction

  function automatic int unsigned eff_height();
    if (frame_height == 0) return 1;
    return frame_height > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : frame_height;
  endfunction

  // Weighted window sum around raster position idx, with the border
  // replicated, then truncated to the integer part and clamped to 255.
  function automatic blur_px_t blur_pixel(int unsigned idx, int w, int h, int r);
    longint unsigned acc_r;
    longint unsigned acc_g;
    longint unsigned acc_b;
    longint unsigned wt;
    logic [23:0] px;
    int y;
    int x;
    int yy;
    int xx;
    blur_px_t res;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    y = idx / w;
    x = idx % w;
    for (int dy = -r; dy <= r; dy++) begin
      yy = y + dy;
      if (yy < 0) yy = 0;
      if (yy > h - 1) yy = h - 1;
      for (int dx = -r; dx <= r; dx++) begin
        xx = x + dx;
        if (xx < 0) xx = 0;
        if (xx > w - 1) xx = w - 1;
        px = row_ring[yy % RING_ROWS][xx];
        wt = longint'(tap_weight[dy < 0 ? -dy : dy]) *
             longint'(tap_weight[dx < 0 ? -dx : dx]);
        acc_r += longint'(px[23:16]) * wt;
        acc_g += longint'(px[15:8]) * wt;
        acc_b += longint'(px[7:0]) * wt;
      end
    end
    acc_r = acc_r >> FRAC_W;
    acc_g = acc_g >> FRAC_W;
    acc_b = acc_b >> FRAC_W;
    res.red = acc_r > 255 ? 8'd255 : acc_r[7:0];
    res.green = acc_g > 255 ? 8'd255 : acc_g[7:0];
    res.blue = acc_b > 255 ? 8'd255 : acc_b[7:0];
    res.last = 1'b0;
    return res;
  endfunction

  // Advances the frame counters by one accepted transfer and tells whether a
  // blurred pixel is released by it.
  task automatic predict_blur(input logic cmd, input logic [23:0] rgb,
                              output bit has, output blur_px_t px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned n;
    int unsigned lag;
    w = eff_width();
    h = eff_height();
    r = blur_radius;
    n = w * h;
    lag = r * w + r;
    has = 0;
    px = '0;
    if (pixels_out >= n || pixels_in > n + lag) begin
      pixels_in = 0;
      pixels_out = 0;
    end
    if (pixels_in < n) begin
      if (cmd == CMD_PIXEL) begin
        row_ring[(pixels_in / w) % RING_ROWS][pixels_in % w] = rgb;
        pixels_in++;
      end
    end else begin
      pixels_in++;
    end
    if (pixels_in > pixels_out + lag) begin
      px = blur_pixel(pixels_out, w, h, r);
      px.last = (pixels_out == n - 1);
      has = 1;
      pixels_out++;
      if (pixels_out >= n) begin
        pixels_in = 0;
        pixels_out = 0;
        frames_done++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // Every output transfer is held against the oldest outstanding expectation.
  always @(posedge clk) begin
    blur_px_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got %0d %0d %0d end %0b",
                 $time, out_red, out_green, out_blue, frame_end);
        failures++;
      end else begin
        want = pending_px.pop_front();
        check_field("out_red", want.red, out_red);
        check_field("out_green", want.green, out_green);
        check_field("out_blue", want.blue, out_blue);
        check_field("frame_end", 8'(want.last), 8'(frame_end));
      end
    end
  end

  // Drives one register write; the caller drops the write enable after the
  // last write of a sequence.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_RADIUS:  blur_radius = val[1:0];
      CFG_WIDTH:   frame_width = val[10:0];
      CFG_HEIGHT:  frame_height = val[12:0];
      CFG_WEIGHT0: tap_weight[0] = val[15:0];
      CFG_WEIGHT1: tap_weight[1] = val[15:0];
      CFG_WEIGHT2: tap_weight[2] = val[15:0];
      CFG_WEIGHT3: tap_weight[3] = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until every expected pixel has come out and the block has had time
  // to finish its window sweep, then rewrites all registers.
  task automatic set_frame(input int unsigned r, input int unsigned w,
                           input int unsigned h, input int unsigned w0,
                           input int unsigned w1, input int unsigned w2,
                           input int unsigned w3);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_WEIGHT0, w0);
    write_reg(CFG_WEIGHT1, w1);
    write_reg(CFG_WEIGHT2, w2);
    write_reg(CFG_WEIGHT3, w3);
    cfg_write <= 1'b0;
  endtask

  // Offers one transfer, optionally after an idle burst, and returns once it
  // has been accepted. Valid stays high so back-to-back transfers need only
  // one assignment per edge.
  task automatic send_item(input logic cmd, input logic [23:0] rgb,
                           output bit has, output blur_px_t px);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    red <= rgb[23:16];
    green <= rgb[15:8];
    blue <= rgb[7:0];
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_blur(cmd, rgb, has, px);
  endtask

  task automatic send_predicted(input logic cmd, input logic [23:0] rgb);
    bit has;
    blur_px_t px;
    send_item(cmd, rgb, has, px);
    if (has) pending_px.push_back(px);
  endtask

  task automatic run_table();
    bit has;
    blur_px_t px;
    dir_row_t row;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.cmd, {row.red, row.green, row.blue}, has, px);
      if (row.typed) begin
        if (row.has) pending_px.push_back(row.px);
      end else if (has) begin
        pending_px.push_back(px);
      end
    end
    dir_rows.delete();
  endtask

  function automatic logic [23:0] rand_rgb();
    logic [23:0] v;
    v = 24'($urandom);
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // One full frame with random content: flush ticks sprinkled in before the
  // frame is complete are ignored by the block, and the trailing steps that
  // drain the window are a random mix of flush ticks and surplus pixels.
  task automatic run_frame();
    int unsigned w;
    int unsigned n;
    int unsigned lag;
    w = eff_width();
    n = w * eff_height();
    lag = blur_radius * w + blur_radius;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_predicted(CMD_FLUSH, rand_rgb());
      send_predicted(CMD_PIXEL, rand_rgb());
    end
    for (int unsigned i = 0; i < lag; i++) begin
      send_predicted($urandom_range(0, 2) == 0 ? CMD_PIXEL : CMD_FLUSH, rand_rgb());
    end
  endtask

  function automatic int unsigned rand_weight();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(4000, 40000);
    endcase
  endfunction

  initial begin
    int unsigned r;
    failures = 0;
    items_sent = 0;
    results_seen = 0;
    frames_done = 0;
    cycles = 0;
    quiet = 0;
    stall_left = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_PIXEL;
    red = '0;
    green = '0;
    blue = '0;
    blur_radius = RADIUS_RST;
    frame_width = WIDTH_RST;
    frame_height = HEIGHT_RST;
    tap_weight[0] = WEIGHT0_RST;
    tap_weight[1] = WEIGHT1_RST;
    tap_weight[2] = WEIGHT2_RST;
    tap_weight[3] = WEIGHT3_RST;
    pixels_in = 0;
    pixels_out = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Radius zero with a near-unity center weight: every pixel comes straight
    // back scaled by just under one, so each channel drops by one step except
    // zero. A flush tick before the frame is complete does nothing.
    set_frame(0, 2, 2, 65535, 0, 0, 0);
    dir_rows.push_back({CMD_PIXEL, 8'd255, 8'd255, 8'd255, 2'b11,
                        8'd254, 8'd254, 8'd254, 1'b0});
    dir_rows.push_back({CMD_PIXEL, 8'd0, 8'd0, 8'd0, 2'b11, 8'd0, 8'd0, 8'd0, 1'b0});
    dir_rows.push_back({CMD_FLUSH, 8'd9, 8'd9, 8'd9, 2'b10, 25'd0});
    dir_rows.push_back({CMD_PIXEL, 8'd255, 8'd0, 8'd128, 2'b11,
                        8'd254, 8'd0, 8'd127, 1'b0});
    dir_rows.push_back({CMD_PIXEL, 8'd1, 8'd2, 8'd3, 2'b11, 8'd0, 8'd1, 8'd2, 1'b1});
    run_table();

    // All weights at full scale: nine near-unity taps on white overflow and
    // must saturate. The last four steps drain the frame; the surplus pixel
    // among them only counts as a flush tick.
    set_frame(1, 2, 2, 65535, 65535, 65535, 65535);
    for (int i = 0; i < 3; i++)
      dir_rows.push_back({CMD_PIXEL, 8'd255, 8'd255, 8'd255, 2'b10, 25'd0});
    dir_rows.push_back({CMD_PIXEL, 8'd255, 8'd255, 8'd255, 2'b11,
                        8'd255, 8'd255, 8'd255, 1'b0});
    dir_rows.push_back({CMD_FLUSH, 24'd0, 2'b11, 8'd255, 8'd255, 8'd255, 1'b0});
    dir_rows.push_back({CMD_PIXEL, 24'd0, 2'b11, 8'd255, 8'd255, 8'd255, 1'b0});
    dir_rows.push_back({CMD_FLUSH, 24'd0, 2'b11, 8'd255, 8'd255, 8'd255, 1'b1});
    run_table();

    // Power-on weights on a 3x2 frame with mixed content, left to the predictor.
    set_frame(1, 3, 2, WEIGHT0_RST, WEIGHT1_RST, WEIGHT2_RST, WEIGHT3_RST);
    dir_rows.push_back({CMD_FLUSH, 24'hFFFFFF, 2'b00, 25'd0});
    for (int i = 0; i < 6; i++)
      dir_rows.push_back({CMD_PIXEL, 8'(i * 51), 8'(255 - i * 40), 8'(i[0] ? 255 : 0),
                          2'b00, 25'd0});
    for (int i = 0; i < 4; i++)
      dir_rows.push_back({i[0] ? CMD_PIXEL : CMD_FLUSH, 24'h123456, 2'b00, 25'd0});
    run_table();

    // Random frames. The first few pin the size extremes: the widest window
    // on a one-pixel frame and on single-column and single-row strips.
    for (int ph = 0; items_sent < 350 || ph < 12; ph++) begin
      case (ph)
        0: set_frame(3, 1, 1, rand_weight(), rand_weight(), rand_weight(), rand_weight());
        1: set_frame(3, 1, 7, rand_weight(), rand_weight(), rand_weight(), rand_weight());
        2: set_frame(3, 8, 1, rand_weight(), rand_weight(), rand_weight(), rand_weight());
        3: set_frame(2, 0, 5, rand_weight(), rand_weight(), rand_weight(), rand_weight());
        default: begin
          r = $urandom_range(0, 3);
          set_frame(r, $urandom_range(1, 7), $urandom_range(1, 7), rand_weight(),
                    rand_weight(), rand_weight(), rand_weight());
        end
      endcase
      run_frame();
      // Hold the sender back once until the block has drained completely.
      if (ph == 5) begin
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
      end
    end

    // The last frames run without any idling on either side; the second one
    // has a zero height, which counts as a single row.
    quiet = 1;
    set_frame(1, 6, 4, 20000, 22000, 0, 0);
    run_frame();
    set_frame(2, 7, 0, rand_weight(), rand_weight(), rand_weight(), rand_weight());
    run_frame();

    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d transfers over %0d complete frames, radius 0 to 3,", items_sent,
             frames_done);
    $display("sizes from one pixel up to 8 wide, zero sizes as one; %0d pixels checked.",
             results_seen);
    if (failures == 0 && pending_px.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
design/gbrs_pkg.sv
design/gbrs_ram.sv
design/gbrs_cell.sv
design/gaussian_blur_rgb_stream.sv
tb/sv/tb.sv
